[design/rgb_to_hsv_hsl_defines.svh]
// Assertion macros for the color conversion block.
`ifndef RGB_TO_HSV_HSL_DEFINES_SVH
`define RGB_TO_HSV_HSL_DEFINES_SVH
`ifndef SYNTH
`define RHH_ASSERT(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("rgb_to_hsv_hsl check failed");
`define RHH_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rgb_to_hsv_hsl check failed");
`else
`define RHH_ASSERT(lbl, clk, rst_n, expr)
`define RHH_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

[design/rhh_pkg.sv]
// Shared widths, codes and stage types of the color conversion block.
package rhh_pkg;
  localparam int CHANNEL_BITS = 8;
  localparam int FULL = (1 << CHANNEL_BITS) - 1;
  localparam int HB = 9;
  localparam int LB = CHANNEL_BITS + 1;
  localparam int QB = (HB > CHANNEL_BITS + 1) ? HB : CHANNEL_BITS + 1;
  localparam int DB = CHANNEL_BITS + 1;
  localparam int NB = DB + QB;
  localparam int HUE_WRAP = 360;
  localparam int HUE_SCALE = 60;
  localparam int OFF_RED = 360;
  localparam int OFF_GREEN = 120;
  localparam int OFF_BLUE = 240;
  localparam int PIPE = QB + 2;

  localparam logic [1:0] MAX_RED = 2'd0;
  localparam logic [1:0] MAX_GREEN = 2'd1;
  localparam logic [1:0] MAX_BLUE = 2'd2;

  typedef struct packed {
    logic [NB-1:0] hue_num;
    logic [DB-1:0] hue_den;
    logic [NB-1:0] sv_num;
    logic [DB-1:0] sv_den;
    logic [NB-1:0] sl_num;
    logic [DB-1:0] sl_den;
  } div_req_t;

  typedef struct packed {
    logic                    grey;
    logic [CHANNEL_BITS-1:0] mx;
    logic [LB-1:0]           sum;
  } side_t;
endpackage

[design/rhh_pix_if.sv]
// Pixel request channel.
interface rhh_pix_if;
  logic                             valid;
  logic                             ready;
  logic [rhh_pkg::CHANNEL_BITS-1:0] red;
  logic [rhh_pkg::CHANNEL_BITS-1:0] green;
  logic [rhh_pkg::CHANNEL_BITS-1:0] blue;
  modport source (output valid, red, green, blue, input ready);
  modport sink (input valid, red, green, blue, output ready);
endinterface

[design/rhh_res_if.sv]
// Result request channel.
interface rhh_res_if;
  logic                             valid;
  logic                             ready;
  logic [rhh_pkg::HB-1:0]           hue_degrees;
  logic [rhh_pkg::CHANNEL_BITS-1:0] hsv_saturation;
  logic [rhh_pkg::CHANNEL_BITS-1:0] hsv_value;
  logic [rhh_pkg::CHANNEL_BITS-1:0] hsl_saturation;
  logic [rhh_pkg::LB-1:0]           lightness_doubled;
  modport source (output valid, hue_degrees, hsv_saturation, hsv_value, hsl_saturation,
                  lightness_doubled, input ready);
  modport sink (input valid, hue_degrees, hsv_saturation, hsv_value, hsl_saturation,
                lightness_doubled, output ready);
endinterface

[design/rhh_front.sv]
// Front stages: extremes, selection and divider operands.
module rhh_front (
  input  logic                             clk,
  input  logic                             en,
  input  logic [rhh_pkg::CHANNEL_BITS-1:0] red,
  input  logic [rhh_pkg::CHANNEL_BITS-1:0] green,
  input  logic [rhh_pkg::CHANNEL_BITS-1:0] blue,
  output rhh_pkg::div_req_t                req,
  output rhh_pkg::side_t                   side
);
  localparam int CB = rhh_pkg::CHANNEL_BITS;
  localparam int NB = rhh_pkg::NB;
  localparam int DB = rhh_pkg::DB;

  logic [CB-1:0] mx_r, mx_nxt, mn_r, mn_nxt, pa_r, pa_nxt, pb_r, pb_nxt;
  logic [1:0]    sel_r, sel_nxt;
  rhh_pkg::div_req_t req_r, req_nxt;
  rhh_pkg::side_t    side_r, side_nxt;
  logic [CB-1:0] d;
  logic [DB-1:0] sum, sden;
  logic [8:0]    off;

  always_comb begin
    mx_nxt = red;
    sel_nxt = rhh_pkg::MAX_RED;
    pa_nxt = green;
    pb_nxt = blue;
    if (!(red >= green && red >= blue)) begin
      if (green >= blue) begin
        mx_nxt = green;
        sel_nxt = rhh_pkg::MAX_GREEN;
        pa_nxt = blue;
        pb_nxt = red;
      end else begin
        mx_nxt = blue;
        sel_nxt = rhh_pkg::MAX_BLUE;
        pa_nxt = red;
        pb_nxt = green;
      end
    end
    mn_nxt = red;
    if (green < mn_nxt) mn_nxt = green;
    if (blue < mn_nxt) mn_nxt = blue;
  end

  always_comb begin
    d = mx_r - mn_r;
    sum = DB'(mx_r) + DB'(mn_r);
    if (sum >= DB'(rhh_pkg::FULL)) sden = DB'(2 * rhh_pkg::FULL) - sum;
    else sden = sum;
    unique case (sel_r)
      rhh_pkg::MAX_RED:   off = 9'(rhh_pkg::OFF_RED);
      rhh_pkg::MAX_GREEN: off = 9'(rhh_pkg::OFF_GREEN);
      rhh_pkg::MAX_BLUE:  off = 9'(rhh_pkg::OFF_BLUE);
      default:            off = 9'(rhh_pkg::OFF_BLUE);
    endcase
    req_nxt.hue_num = NB'(2) * (NB'(off) * NB'(d) + NB'(rhh_pkg::HUE_SCALE) * NB'(pa_r))
                      + NB'(d) - NB'(2 * rhh_pkg::HUE_SCALE) * NB'(pb_r);
    req_nxt.hue_den = {d, 1'b0};
    req_nxt.sv_num = NB'(2 * rhh_pkg::FULL) * NB'(d) + NB'(mx_r);
    req_nxt.sv_den = {mx_r, 1'b0};
    req_nxt.sl_num = NB'(2 * rhh_pkg::FULL) * NB'(d) + NB'(sden);
    req_nxt.sl_den = DB'({sden, 1'b0});
    side_nxt.grey = (d == '0);
    side_nxt.mx = mx_r;
    side_nxt.sum = sum;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mx_r <= mx_nxt;
      mn_r <= mn_nxt;
      pa_r <= pa_nxt;
      pb_r <= pb_nxt;
      sel_r <= sel_nxt;
      req_r <= req_nxt;
      side_r <= side_nxt;
    end
  end

  assign req = req_r;
  assign side = side_r;
endmodule

[design/rhh_div.sv]
// Restoring divider, one quotient bit per pipeline stage.
module rhh_div (
  input  logic                    clk,
  input  logic                    en,
  input  logic [rhh_pkg::NB-1:0]  num,
  input  logic [rhh_pkg::DB-1:0]  den,
  output logic [rhh_pkg::QB-1:0]  quo
);
  localparam int QB = rhh_pkg::QB;
  localparam int NB = rhh_pkg::NB;
  localparam int DB = rhh_pkg::DB;

  logic [NB-1:0] rem_r [QB];
  logic [DB-1:0] den_r [QB];
  logic [QB-1:0] q_r [QB];

  for (genvar k = 0; k < QB; k++) begin : g_stage
    logic [NB-1:0] rem_in, shd, rem_nxt;
    logic [DB-1:0] den_in;
    logic [QB-1:0] q_in, q_nxt;
    if (k == 0) begin : g_first
      assign rem_in = num;
      assign den_in = den;
      assign q_in = '0;
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign den_in = den_r[k-1];
      assign q_in = q_r[k-1];
    end
    always_comb begin
      shd = NB'(den_in) << (QB - 1 - k);
      rem_nxt = rem_in;
      q_nxt = q_in;
      if (rem_in >= shd) begin
        rem_nxt = rem_in - shd;
        q_nxt[QB-1-k] = 1'b1;
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= rem_nxt;
        den_r[k] <= den_in;
        q_r[k] <= q_nxt;
      end
    end
  end

  assign quo = q_r[QB-1];
endmodule

[design/rgb_to_hsv_hsl.sv]
// Top level of the pipelined RGB to HSV and HSL converter.
// Usage:
//   in_pix carries one pixel (red, green, blue) per request under valid/ready.
//   out_res carries hue in degrees, HSV saturation and value, HSL saturation
//   and doubled lightness per request under valid/ready.
//   One result is given for every pixel, in order.
// Pipeline: the accepting edge loads the first of two front stages, then one
//   stage per quotient bit in three parallel dividers, and the output
//   register.
// Throughput: one pixel per cycle while the receiver takes results.
// Reset clears all valid bits; the pipeline comes up empty and ready.
// When the receiver stalls with a result held, the whole pipeline holds and
//   in_pix.ready drops; nothing is lost or repeated.
`include "rgb_to_hsv_hsl_defines.svh"
module rgb_to_hsv_hsl (
  input  logic       clk,
  input  logic       rst_n,
  rhh_pix_if.sink    in_pix,
  rhh_res_if.source  out_res
);
  localparam int CB = rhh_pkg::CHANNEL_BITS;
  localparam int QB = rhh_pkg::QB;
  localparam int PIPE = rhh_pkg::PIPE;

  logic adv;
  logic [PIPE-1:0] vl_r, vl_nxt;
  logic out_valid_r;
  rhh_pkg::div_req_t req;
  rhh_pkg::side_t    side;
  rhh_pkg::side_t    side_r [QB];
  logic [QB-1:0] hue_q, sv_q, sl_q, hue_w;
  logic [rhh_pkg::HB-1:0] hue_r, hue_nxt;
  logic [CB-1:0] sv_r, sv_nxt, sl_r, sl_nxt, mx_r;
  logic [rhh_pkg::LB-1:0] sum_r;

  assign adv = !out_valid_r || out_res.ready;
  assign in_pix.ready = adv;
  assign vl_nxt = {vl_r[PIPE-2:0], in_pix.valid};

  rhh_front u_front (
    .clk(clk), .en(adv), .red(in_pix.red), .green(in_pix.green), .blue(in_pix.blue),
    .req(req), .side(side)
  );

  rhh_div u_div_hue (.clk(clk), .en(adv), .num(req.hue_num), .den(req.hue_den), .quo(hue_q));
  rhh_div u_div_sv (.clk(clk), .en(adv), .num(req.sv_num), .den(req.sv_den), .quo(sv_q));
  rhh_div u_div_sl (.clk(clk), .en(adv), .num(req.sl_num), .den(req.sl_den), .quo(sl_q));

  always_ff @(posedge clk) begin
    if (adv) begin
      side_r[0] <= side;
      for (int k = 1; k < QB; k++) side_r[k] <= side_r[k-1];
    end
  end

  always_comb begin
    hue_w = hue_q;
    if (hue_q >= QB'(rhh_pkg::HUE_WRAP)) hue_w = hue_q - QB'(rhh_pkg::HUE_WRAP);
    hue_nxt = side_r[QB-1].grey ? '0 : rhh_pkg::HB'(hue_w);
    sv_nxt = side_r[QB-1].grey ? '0 : CB'(sv_q);
    sl_nxt = side_r[QB-1].grey ? '0 : CB'(sl_q);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vl_r <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      vl_r <= vl_nxt;
      out_valid_r <= vl_r[PIPE-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      hue_r <= hue_nxt;
      sv_r <= sv_nxt;
      sl_r <= sl_nxt;
      mx_r <= side_r[QB-1].mx;
      sum_r <= side_r[QB-1].sum;
    end
  end

  assign out_res.valid = out_valid_r;
  assign out_res.hue_degrees = hue_r;
  assign out_res.hsv_saturation = sv_r;
  assign out_res.hsv_value = mx_r;
  assign out_res.hsl_saturation = sl_r;
  assign out_res.lightness_doubled = sum_r;

  `RHH_ASSERT(a_hue_range, clk, rst_n, !out_valid_r || hue_r < rhh_pkg::HB'(rhh_pkg::HUE_WRAP))
  `RHH_ASSERT(a_black_sat, clk, rst_n, !out_valid_r || mx_r != '0 || sv_r == '0)
  `RHH_ASSERT(a_light_ge_val, clk, rst_n, !out_valid_r || sum_r >= rhh_pkg::LB'(mx_r))
  `RHH_ASSERT_NEXT(a_stall_hold, clk, rst_n, !adv, $stable(vl_r))
endmodule
